// ===== rtl/tch_pkg.sv =====
package tch_pkg;

    localparam int DEF_CORDIC_STEPS = 16;
    localparam int DEF_SAMPLE_BITS  = 16;

    // angle accumulator in 2^-24 rad units
    localparam int ZW   = 28;
    // rotation datapath, Q30 start value plus gain headroom
    localparam int RW   = 33;
    // sin and cos in Q15
    localparam int CS_W = 18;
    // Q3.13 angle
    localparam int Q_W  = 17;

    localparam int TILT_W  = 14;
    localparam int HEAD_W  = 9;
    localparam int PROD_W  = 34;

    localparam logic [TILT_W-1:0] TILT_RESET  = 14'd6390;
    localparam logic [HEAD_W-1:0] HEAD_MAX    = 9'd359;
    localparam logic [Q_W-1:0]    Q13_TWO_PI  = 17'd51472;
    localparam logic [Q_W-1:0]    DEG_FACTOR  = 17'd117342;

    localparam logic signed [ZW-1:0] ANG_PI      = 28'sd52707179;
    localparam logic signed [ZW-1:0] ANG_HALF_PI = 28'sd26353589;
    localparam logic signed [RW-1:0] INV_GAIN    = 33'sd652032874;

    function automatic logic signed [ZW-1:0] atan_at(input int i);
        logic signed [ZW-1:0] v;
        case (i)
            0:       v = 28'sd13176795;
            1:       v = 28'sd7778716;
            2:       v = 28'sd4110060;
            3:       v = 28'sd2086331;
            4:       v = 28'sd1047214;
            5:       v = 28'sd524117;
            6:       v = 28'sd262123;
            7:       v = 28'sd131069;
            8:       v = 28'sd65536;
            9:       v = 28'sd32768;
            10:      v = 28'sd16384;
            11:      v = 28'sd8192;
            12:      v = 28'sd4096;
            13:      v = 28'sd2048;
            14:      v = 28'sd1024;
            15:      v = 28'sd512;
            16:      v = 28'sd256;
            17:      v = 28'sd128;
            18:      v = 28'sd64;
            19:      v = 28'sd32;
            20:      v = 28'sd16;
            21:      v = 28'sd8;
            22:      v = 28'sd4;
            23:      v = 28'sd2;
            default: v = 28'sd0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/tch_vec_pre.sv =====
// quadrant pre-rotation for vectoring: brings x into the right half plane
module tch_vec_pre
    import tch_pkg::*;
#(
    parameter int W = 38
) (
    input  logic signed [W-1:0]  i_x,
    input  logic signed [W-1:0]  i_y,
    output logic signed [W-1:0]  o_x,
    output logic signed [W-1:0]  o_y,
    output logic signed [ZW-1:0] o_z,
    output logic                 o_zero
);
    always_comb begin
        o_zero = (i_x == '0) && (i_y == '0);
        o_x = i_x;
        o_y = i_y;
        o_z = '0;
        if (i_x < 0) begin
            if (i_y >= 0) begin
                o_x = i_y;
                o_y = -i_x;
                o_z = ANG_HALF_PI;
            end else begin
                o_x = -i_y;
                o_y = i_x;
                o_z = -ANG_HALF_PI;
            end
        end
    end
endmodule

// ===== rtl/tch_vec_cell.sv =====
// one vectoring micro-rotation, drives y toward zero
module tch_vec_cell
    import tch_pkg::*;
#(
    parameter int W    = 38,
    parameter int TW   = 1,
    parameter int STEP = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_vld,
    input  logic signed [W-1:0]  i_x,
    input  logic signed [W-1:0]  i_y,
    input  logic signed [ZW-1:0] i_z,
    input  logic [TW-1:0]        i_tag,
    output logic                 o_vld,
    output logic signed [W-1:0]  o_x,
    output logic signed [W-1:0]  o_y,
    output logic signed [ZW-1:0] o_z,
    output logic [TW-1:0]        o_tag
);
    localparam logic signed [ZW-1:0] ATAN = atan_at(STEP);

    logic                 r_vld;
    logic signed [W-1:0]  r_x, r_y;
    logic signed [ZW-1:0] r_z;
    logic [TW-1:0]        r_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
        if (i_y >= 0) begin
            r_x <= i_x + (i_y >>> STEP);
            r_y <= i_y - (i_x >>> STEP);
            r_z <= i_z + ATAN;
        end else begin
            r_x <= i_x - (i_y >>> STEP);
            r_y <= i_y + (i_x >>> STEP);
            r_z <= i_z - ATAN;
        end
        r_tag <= i_tag;
    end

    assign o_vld = r_vld;
    assign o_x   = r_x;
    assign o_y   = r_y;
    assign o_z   = r_z;
    assign o_tag = r_tag;
endmodule

// ===== rtl/tch_rot_cell.sv =====
// one rotation micro-rotation, drives z toward zero
module tch_rot_cell
    import tch_pkg::*;
#(
    parameter int TW   = 1,
    parameter int STEP = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_vld,
    input  logic signed [RW-1:0] i_x,
    input  logic signed [RW-1:0] i_y,
    input  logic signed [ZW-1:0] i_z,
    input  logic [TW-1:0]        i_tag,
    output logic                 o_vld,
    output logic signed [RW-1:0] o_x,
    output logic signed [RW-1:0] o_y,
    output logic signed [ZW-1:0] o_z,
    output logic [TW-1:0]        o_tag
);
    localparam logic signed [ZW-1:0] ATAN = atan_at(STEP);

    logic                 r_vld;
    logic signed [RW-1:0] r_x, r_y;
    logic signed [ZW-1:0] r_z;
    logic [TW-1:0]        r_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
        if (i_z >= 0) begin
            r_x <= i_x - (i_y >>> STEP);
            r_y <= i_y + (i_x >>> STEP);
            r_z <= i_z - ATAN;
        end else begin
            r_x <= i_x + (i_y >>> STEP);
            r_y <= i_y - (i_x >>> STEP);
            r_z <= i_z + ATAN;
        end
        r_tag <= i_tag;
    end

    assign o_vld = r_vld;
    assign o_x   = r_x;
    assign o_y   = r_y;
    assign o_z   = r_z;
    assign o_tag = r_tag;
endmodule

// ===== rtl/tilt_compensated_heading.sv =====
// channel   direction  handshake                      word
// sample    in         start (busy is always low)     six axis readings
// config    in         i_cfg_valid / o_cfg_ready      tilt limit, unsigned Q1.13
// result    out        o_strobe, one cycle            heading, tilt flag
//
// Fully pipelined: one sample per cycle through three chains of CORDIC cells
// (roll/pitch atan2, sin/cos, heading atan2) plus the multiply and conversion
// stages. Reset clears the valid bits and loads the default tilt limit. The
// receiver cannot stall, so nothing backs up.
module tilt_compensated_heading
    import tch_pkg::*;
#(
    parameter int CORDIC_STEPS = DEF_CORDIC_STEPS,
    parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [SAMPLE_BITS-1:0] i_mag_x,
    input  logic signed [SAMPLE_BITS-1:0] i_mag_y,
    input  logic signed [SAMPLE_BITS-1:0] i_mag_z,
    input  logic signed [SAMPLE_BITS-1:0] i_acc_x,
    input  logic signed [SAMPLE_BITS-1:0] i_acc_y,
    input  logic signed [SAMPLE_BITS-1:0] i_acc_z,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [TILT_W-1:0]             i_cfg_data,
    output logic                          o_strobe,
    output logic [HEAD_W-1:0]             o_heading_deg,
    output logic                          o_tilt_exceeded
);
    localparam int SB  = SAMPLE_BITS;
    localparam int N   = CORDIC_STEPS;
    localparam int CW  = SB + 22;
    localparam int MW  = 3 * SB;
    localparam int PW  = SB + CS_W;
    localparam int XW  = PW + 1;
    localparam int TSW = XW + CS_W;
    localparam int LAT = 3 * CORDIC_STEPS + 10;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    logic [TILT_W-1:0] r_tilt_limit;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tilt_limit <= TILT_RESET;
        end else if (i_cfg_valid) begin
            r_tilt_limit <= i_cfg_data;
        end
    end

    // input register
    logic                 r_s0_vld;
    logic signed [SB-1:0] r_mx, r_my, r_mz, r_ax, r_ay, r_az;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
        end else begin
            r_s0_vld <= start;
        end
        r_mx <= i_mag_x;
        r_my <= i_mag_y;
        r_mz <= i_mag_z;
        r_ax <= i_acc_x;
        r_ay <= i_acc_y;
        r_az <= i_acc_z;
    end

    // roll and pitch atan2
    logic signed [SB:0]   neg_ax;
    logic signed [CW-1:0] rv_xi, rv_yi, pv_yi;
    logic signed [CW-1:0] rv_x0, rv_y0, pv_x0, pv_y0;
    logic signed [ZW-1:0] rv_z0, pv_z0;
    logic                 rv_zero, pv_zero;

    assign neg_ax = -$signed({r_ax[SB-1], r_ax});
    assign rv_xi  = {{6{r_az[SB-1]}}, r_az, 16'b0};
    assign rv_yi  = {{6{r_ay[SB-1]}}, r_ay, 16'b0};
    assign pv_yi  = {{5{neg_ax[SB]}}, neg_ax, 16'b0};

    tch_vec_pre #(.W(CW)) u_roll_pre (
        .i_x(rv_xi), .i_y(rv_yi), .o_x(rv_x0), .o_y(rv_y0), .o_z(rv_z0), .o_zero(rv_zero)
    );
    tch_vec_pre #(.W(CW)) u_pitch_pre (
        .i_x(rv_xi), .i_y(pv_yi), .o_x(pv_x0), .o_y(pv_y0), .o_z(pv_z0), .o_zero(pv_zero)
    );

    logic                 rv_vld [0:N];
    logic                 pv_vld [0:N];
    logic signed [CW-1:0] rv_x [0:N];
    logic signed [CW-1:0] rv_y [0:N];
    logic signed [ZW-1:0] rv_z [0:N];
    logic [MW:0]          rv_tag [0:N];
    logic signed [CW-1:0] pv_x [0:N];
    logic signed [CW-1:0] pv_y [0:N];
    logic signed [ZW-1:0] pv_z [0:N];
    logic [0:0]           pv_tag [0:N];

    assign rv_vld[0] = r_s0_vld;
    assign rv_x[0]   = rv_x0;
    assign rv_y[0]   = rv_y0;
    assign rv_z[0]   = rv_z0;
    assign rv_tag[0] = {rv_zero, r_mx, r_my, r_mz};
    assign pv_vld[0] = r_s0_vld;
    assign pv_x[0]   = pv_x0;
    assign pv_y[0]   = pv_y0;
    assign pv_z[0]   = pv_z0;
    assign pv_tag[0] = pv_zero;

    for (genvar g = 0; g < N; g++) begin : g_tilt
        tch_vec_cell #(.W(CW), .TW(MW + 1), .STEP(g)) u_roll (
            .i_clk(i_clk), .i_rst_n(i_rst_n),
            .i_vld(rv_vld[g]), .i_x(rv_x[g]), .i_y(rv_y[g]), .i_z(rv_z[g]),
            .i_tag(rv_tag[g]),
            .o_vld(rv_vld[g+1]), .o_x(rv_x[g+1]), .o_y(rv_y[g+1]), .o_z(rv_z[g+1]),
            .o_tag(rv_tag[g+1])
        );
        tch_vec_cell #(.W(CW), .TW(1), .STEP(g)) u_pitch (
            .i_clk(i_clk), .i_rst_n(i_rst_n),
            .i_vld(pv_vld[g]), .i_x(pv_x[g]), .i_y(pv_y[g]), .i_z(pv_z[g]),
            .i_tag(pv_tag[g]),
            .o_vld(pv_vld[g+1]), .o_x(pv_x[g+1]), .o_y(pv_y[g+1]), .o_z(pv_z[g+1]),
            .o_tag(pv_tag[g+1])
        );
    end

    // round to Q3.13 and check the tilt limit
    logic signed [ZW-1:0] roll_rnd, pitch_rnd;
    logic signed [Q_W-1:0] roll_q, pitch_q, lim_s;
    assign roll_rnd  = rv_z[N] + ZW'(1024);
    assign pitch_rnd = pv_z[N] + ZW'(1024);
    assign roll_q    = rv_tag[N][MW] ? '0 : roll_rnd[ZW-1:11];
    assign pitch_q   = pv_tag[N][0]  ? '0 : pitch_rnd[ZW-1:11];
    assign lim_s     = $signed({{(Q_W-TILT_W){1'b0}}, r_tilt_limit});

    logic                  r_s1_vld, r_s1_tilt;
    logic signed [Q_W-1:0] r_roll, r_pitch;
    logic [MW-1:0]         r_s1_mag;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= rv_vld[N] & pv_vld[N];
        end
        r_roll    <= roll_q;
        r_pitch   <= pitch_q;
        r_s1_tilt <= (roll_q > lim_s) || (roll_q < -lim_s) ||
                     (pitch_q > lim_s) || (pitch_q < -lim_s);
        r_s1_mag  <= rv_tag[N][MW-1:0];
    end

    // sin/cos: fold into [-pi/2, pi/2], flip sign afterwards
    logic signed [ZW-1:0] rz_in, pz_in, rz_red, pz_red;
    logic                 r_flip, p_flip;
    assign rz_in = {r_roll, 11'b0};
    assign pz_in = {r_pitch, 11'b0};
    always_comb begin
        rz_red = rz_in;
        r_flip = 1'b0;
        if (rz_in > ANG_HALF_PI) begin
            rz_red = rz_in - ANG_PI;
            r_flip = 1'b1;
        end else if (rz_in < -ANG_HALF_PI) begin
            rz_red = rz_in + ANG_PI;
            r_flip = 1'b1;
        end
        pz_red = pz_in;
        p_flip = 1'b0;
        if (pz_in > ANG_HALF_PI) begin
            pz_red = pz_in - ANG_PI;
            p_flip = 1'b1;
        end else if (pz_in < -ANG_HALF_PI) begin
            pz_red = pz_in + ANG_PI;
            p_flip = 1'b1;
        end
    end

    logic                 rr_vld [0:N];
    logic                 pr_vld [0:N];
    logic signed [RW-1:0] rr_x [0:N];
    logic signed [RW-1:0] rr_y [0:N];
    logic signed [ZW-1:0] rr_z [0:N];
    logic [MW+1:0]        rr_tag [0:N];
    logic signed [RW-1:0] pr_x [0:N];
    logic signed [RW-1:0] pr_y [0:N];
    logic signed [ZW-1:0] pr_z [0:N];
    logic [0:0]           pr_tag [0:N];

    assign rr_vld[0] = r_s1_vld;
    assign rr_x[0]   = INV_GAIN;
    assign rr_y[0]   = '0;
    assign rr_z[0]   = rz_red;
    assign rr_tag[0] = {r_s1_tilt, r_flip, r_s1_mag};
    assign pr_vld[0] = r_s1_vld;
    assign pr_x[0]   = INV_GAIN;
    assign pr_y[0]   = '0;
    assign pr_z[0]   = pz_red;
    assign pr_tag[0] = p_flip;

    for (genvar g = 0; g < N; g++) begin : g_trig
        tch_rot_cell #(.TW(MW + 2), .STEP(g)) u_roll (
            .i_clk(i_clk), .i_rst_n(i_rst_n),
            .i_vld(rr_vld[g]), .i_x(rr_x[g]), .i_y(rr_y[g]), .i_z(rr_z[g]),
            .i_tag(rr_tag[g]),
            .o_vld(rr_vld[g+1]), .o_x(rr_x[g+1]), .o_y(rr_y[g+1]), .o_z(rr_z[g+1]),
            .o_tag(rr_tag[g+1])
        );
        tch_rot_cell #(.TW(1), .STEP(g)) u_pitch (
            .i_clk(i_clk), .i_rst_n(i_rst_n),
            .i_vld(pr_vld[g]), .i_x(pr_x[g]), .i_y(pr_y[g]), .i_z(pr_z[g]),
            .i_tag(pr_tag[g]),
            .o_vld(pr_vld[g+1]), .o_x(pr_x[g+1]), .o_y(pr_y[g+1]), .o_z(pr_z[g+1]),
            .o_tag(pr_tag[g+1])
        );
    end

    logic signed [RW-1:0] cr_f, sr_f, cp_f, sp_f;
    assign cr_f = rr_tag[N][MW] ? -rr_x[N] : rr_x[N];
    assign sr_f = rr_tag[N][MW] ? -rr_y[N] : rr_y[N];
    assign cp_f = pr_tag[N][0]  ? -pr_x[N] : pr_x[N];
    assign sp_f = pr_tag[N][0]  ? -pr_y[N] : pr_y[N];

    logic                   r_s2_vld, r_s2_tilt;
    logic signed [CS_W-1:0] r_cr, r_sr, r_cp, r_sp;
    logic signed [SB-1:0]   r_s2_mx, r_s2_my, r_s2_mz;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= rr_vld[N] & pr_vld[N];
        end
        r_cr      <= cr_f[RW-1:15];
        r_sr      <= sr_f[RW-1:15];
        r_cp      <= cp_f[RW-1:15];
        r_sp      <= sp_f[RW-1:15];
        r_s2_tilt <= rr_tag[N][MW+1];
        r_s2_mx   <= rr_tag[N][MW-1:2*SB];
        r_s2_my   <= rr_tag[N][2*SB-1:SB];
        r_s2_mz   <= rr_tag[N][SB-1:0];
    end

    // rotate the field vector into the horizontal plane
    logic                   r_m1_vld, r_m1_tilt;
    logic signed [PW-1:0]   r_p1, r_p2, r_p3, r_p4, r_p5;
    logic signed [CS_W-1:0] r_m1_sr;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_vld <= 1'b0;
        end else begin
            r_m1_vld <= r_s2_vld;
        end
        r_p1      <= PW'(r_s2_mx * r_cp);
        r_p2      <= PW'(r_s2_mz * r_sp);
        r_p3      <= PW'(r_s2_mx * r_sp);
        r_p4      <= PW'(r_s2_mz * r_cp);
        r_p5      <= PW'(r_s2_my * r_cr);
        r_m1_sr   <= r_sr;
        r_m1_tilt <= r_s2_tilt;
    end

    logic                   r_m2_vld, r_m2_tilt;
    logic signed [XW-1:0]   r_xh, r_t;
    logic signed [PW-1:0]   r_m2_p5;
    logic signed [CS_W-1:0] r_m2_sr;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m2_vld <= 1'b0;
        end else begin
            r_m2_vld <= r_m1_vld;
        end
        r_xh      <= XW'(r_p1) + XW'(r_p2);
        r_t       <= XW'(r_p3) - XW'(r_p4);
        r_m2_p5   <= r_p5;
        r_m2_sr   <= r_m1_sr;
        r_m2_tilt <= r_m1_tilt;
    end

    logic                  r_m3_vld, r_m3_tilt;
    logic signed [TSW-1:0] r_ts;
    logic signed [XW-1:0]  r_m3_xh;
    logic signed [PW-1:0]  r_m3_p5;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m3_vld <= 1'b0;
        end else begin
            r_m3_vld <= r_m2_vld;
        end
        r_ts      <= TSW'(r_t * r_m2_sr);
        r_m3_xh   <= r_xh;
        r_m3_p5   <= r_m2_p5;
        r_m3_tilt <= r_m2_tilt;
    end

    logic                 r_m4_vld, r_m4_tilt;
    logic signed [CW-1:0] r_hx, r_hy;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m4_vld <= 1'b0;
        end else begin
            r_m4_vld <= r_m3_vld;
        end
        r_hy      <= $signed(r_ts[TSW-1:15]) + CW'(r_m3_p5);
        r_hx      <= CW'(r_m3_xh);
        r_m4_tilt <= r_m3_tilt;
    end

    // heading atan2
    logic signed [CW-1:0] hv_x0, hv_y0;
    logic signed [ZW-1:0] hv_z0;
    logic                 hv_zero;
    tch_vec_pre #(.W(CW)) u_head_pre (
        .i_x(r_hx), .i_y(r_hy), .o_x(hv_x0), .o_y(hv_y0), .o_z(hv_z0), .o_zero(hv_zero)
    );

    logic                 hv_vld [0:N];
    logic signed [CW-1:0] hv_x [0:N];
    logic signed [CW-1:0] hv_y [0:N];
    logic signed [ZW-1:0] hv_z [0:N];
    logic [1:0]           hv_tag [0:N];

    assign hv_vld[0] = r_m4_vld;
    assign hv_x[0]   = hv_x0;
    assign hv_y[0]   = hv_y0;
    assign hv_z[0]   = hv_z0;
    assign hv_tag[0] = {r_m4_tilt, hv_zero};

    for (genvar g = 0; g < N; g++) begin : g_head
        tch_vec_cell #(.W(CW), .TW(2), .STEP(g)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n),
            .i_vld(hv_vld[g]), .i_x(hv_x[g]), .i_y(hv_y[g]), .i_z(hv_z[g]),
            .i_tag(hv_tag[g]),
            .o_vld(hv_vld[g+1]), .o_x(hv_x[g+1]), .o_y(hv_y[g+1]), .o_z(hv_z[g+1]),
            .o_tag(hv_tag[g+1])
        );
    end

    // wrap to [0, 2*pi) and scale to degrees
    logic signed [ZW-1:0]  head_rnd;
    logic signed [Q_W-1:0] head_q;
    assign head_rnd = hv_z[N] + ZW'(1024);
    assign head_q   = hv_tag[N][0] ? '0 : head_rnd[ZW-1:11];

    logic           r_s3_vld, r_s3_tilt;
    logic [Q_W-1:0] r_q;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else begin
            r_s3_vld <= hv_vld[N];
        end
        r_q       <= (head_q < 0) ? Q_W'(head_q) + Q13_TWO_PI : Q_W'(head_q);
        r_s3_tilt <= hv_tag[N][1];
    end

    logic              r_s4_vld, r_s4_tilt;
    logic [PROD_W-1:0] r_prod;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_vld <= 1'b0;
        end else begin
            r_s4_vld <= r_s3_vld;
        end
        r_prod    <= PROD_W'(r_q) * PROD_W'(DEG_FACTOR);
        r_s4_tilt <= r_s3_tilt;
    end

    logic [HEAD_W:0]   deg;
    logic [HEAD_W-1:0] deg_sat;
    assign deg     = r_prod[PROD_W-1:24];
    assign deg_sat = (deg > {1'b0, HEAD_MAX}) ? HEAD_MAX : deg[HEAD_W-1:0];

    logic              r_out_vld, r_out_tilt;
    logic [HEAD_W-1:0] r_out_head;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_s4_vld;
        end
        r_out_head <= r_s4_tilt ? '0 : deg_sat;
        r_out_tilt <= r_s4_tilt;
    end

    assign o_strobe        = r_out_vld;
    assign o_heading_deg   = r_out_head;
    assign o_tilt_exceeded = r_out_tilt;

`ifndef SYNTH
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##LAT o_strobe)
        else $error("sample did not come out after pipeline latency");
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start, LAT))
        else $error("result word without a matching sample");
    a_tilt_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_tilt_exceeded) |-> (o_heading_deg == '0))
        else $error("nonzero heading with tilt flag set");
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_heading_deg <= HEAD_MAX))
        else $error("heading out of range");
`endif

endmodule

// ===== sim/tb_tilt_compensated_heading.sv =====
module tb_tilt_compensated_heading;
    import tch_pkg::*;

    localparam int LATENCY  = 3 * DEF_CORDIC_STEPS + 10;
    localparam int IDLE_MAX = 5000;
    localparam int PHASE_N  = 320;

    typedef struct {
        logic signed [15:0] mx, my, mz, ax, ay, az;
    } t_axes;

    typedef struct {
        logic [HEAD_W-1:0] heading;
        logic              tilted;
    } t_heading;

    class heading_board;
        longint   tilt_lim;
        t_heading pending[$];
        int       fails;
        longint   arctab[16] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117,
                                 262123, 131069, 65536, 32768, 16384, 8192, 4096,
                                 2048, 1024, 512};

        function new();
            tilt_lim = TILT_RESET;
            fails    = 0;
        endfunction

        // vectoring, result in Q3.13
        function longint angle_of(longint y, longint x);
            longint z, t, dx, dy;
            z = 0;
            if (x == 0 && y == 0) return 0;
            if (x < 0) begin
                t = x;
                if (y >= 0) begin
                    x = y; y = -t; z = ANG_HALF_PI;
                end else begin
                    x = -y; y = t; z = -ANG_HALF_PI;
                end
            end
            for (int i = 0; i < 16; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (y >= 0) begin
                    x += dx; y -= dy; z += arctab[i];
                end else begin
                    x -= dx; y += dy; z -= arctab[i];
                end
            end
            return (z + 1024) >>> 11;
        endfunction

        // rotation from a Q3.13 angle, Q15 out
        function void rotate(input longint a13, output longint c, output longint s);
            longint z, x, y, dx, dy;
            bit flip;
            z = a13 * 2048;
            x = INV_GAIN;
            y = 0;
            flip = 0;
            if (z > ANG_HALF_PI) begin
                z -= ANG_PI; flip = 1;
            end else if (z < -ANG_HALF_PI) begin
                z += ANG_PI; flip = 1;
            end
            for (int i = 0; i < 16; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x -= dx; y += dy; z -= arctab[i];
                end else begin
                    x += dx; y -= dy; z += arctab[i];
                end
            end
            if (flip) begin
                x = -x; y = -y;
            end
            c = x >>> 15;
            s = y >>> 15;
        endfunction

        function void note_sample(t_axes a);
            longint mx, my, mz, ax, ay, az, roll, pitch, cr, sr, cp, sp, xh, yh, t, q, deg;
            t_heading e;
            mx = a.mx; my = a.my; mz = a.mz;
            ax = -longint'(a.ax); ay = a.ay; az = a.az;
            roll  = angle_of(ay * 65536, az * 65536);
            pitch = angle_of(ax * 65536, az * 65536);
            if (roll > tilt_lim || roll < -tilt_lim || pitch > tilt_lim || pitch < -tilt_lim)
            begin
                e.heading = '0;
                e.tilted  = 1'b1;
            end else begin
                rotate(roll, cr, sr);
                rotate(pitch, cp, sp);
                xh = mx * cp + mz * sp;
                t  = mx * sp - mz * cp;
                yh = ((t * sr) >>> 15) + my * cr;
                q  = angle_of(yh, xh);
                if (q < 0) q += Q13_TWO_PI;
                deg = (q * DEG_FACTOR) >>> 24;
                if (deg > HEAD_MAX) deg = HEAD_MAX;
                e.heading = deg[HEAD_W-1:0];
                e.tilted  = 1'b0;
            end
            pending.push_back(e);
        endfunction

        function void check_heading(logic [HEAD_W-1:0] hd, logic tl);
            t_heading e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected word heading=%0d tilt=%0b", $time, hd, tl);
                fails++;
                return;
            end
            e = pending.pop_front();
            if (hd !== e.heading) begin
                $display("%0t: heading exp %0d got %0d", $time, e.heading, hd);
                fails++;
            end
            if (tl !== e.tilted) begin
                $display("%0t: tilt flag exp %0b got %0b", $time, e.tilted, tl);
                fails++;
            end
        endfunction
    endclass

    logic i_clk, i_rst_n, start, busy, i_cfg_valid, o_cfg_ready, o_strobe, o_tilt_exceeded;
    logic signed [15:0] i_mag_x, i_mag_y, i_mag_z, i_acc_x, i_acc_y, i_acc_z;
    logic [TILT_W-1:0] i_cfg_data;
    logic [HEAD_W-1:0] o_heading_deg;
    heading_board sb;
    int idle_cycles;

    tilt_compensated_heading dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_mag_x(i_mag_x), .i_mag_y(i_mag_y), .i_mag_z(i_mag_z),
        .i_acc_x(i_acc_x), .i_acc_y(i_acc_y), .i_acc_z(i_acc_z),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .o_strobe(o_strobe), .o_heading_deg(o_heading_deg),
        .o_tilt_exceeded(o_tilt_exceeded)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) sb.check_heading(o_heading_deg, o_tilt_exceeded);
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe || (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_MAX) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send_sample(t_axes a);
        int gap;
        i_mag_x <= a.mx; i_mag_y <= a.my; i_mag_z <= a.mz;
        i_acc_x <= a.ax; i_acc_y <= a.ay; i_acc_z <= a.az;
        start   <= 1'b1;
        do @(posedge i_clk); while (busy);
        sb.note_sample(a);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.pending.size() > 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    task automatic write_limit(logic [TILT_W-1:0] v);
        drain();
        i_cfg_data  <= v;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.tilt_lim = v;
    endtask

    function automatic logic signed [15:0] any16();
        return 16'($urandom_range(0, 65535));
    endfunction

    // within-range value of magnitude up to m
    function automatic logic signed [15:0] near(int m);
        return 16'($urandom_range(0, 2 * m) - m);
    endfunction

    function automatic t_axes mk(int mx, int my, int mz, int ax, int ay, int az);
        t_axes a;
        a.mx = 16'(mx); a.my = 16'(my); a.mz = 16'(mz);
        a.ax = 16'(ax); a.ay = 16'(ay); a.az = 16'(az);
        return a;
    endfunction

    function automatic t_axes rand_axes();
        t_axes a;
        int g;
        a.mx = any16(); a.my = any16(); a.mz = any16();
        if ($urandom_range(0, 4) != 0) begin
            // gravity mainly along +z or -z, roll and pitch within 45 degrees of that axis
            g = $urandom_range(1000, 32767);
            a.az = ($urandom_range(0, 7) == 0) ? -16'(g) : 16'(g);
            a.ax = near(g);
            a.ay = near(g);
            if ($urandom_range(0, 3) == 0) begin
                a.mx = near(300); a.my = near(300); a.mz = near(300);
            end
        end else begin
            a.ax = any16(); a.ay = any16(); a.az = any16();
        end
        return a;
    endfunction

    initial begin
        logic [TILT_W-1:0] limits[5];
        sb = new();
        i_rst_n <= 1'b0; start <= 1'b0; i_cfg_valid <= 1'b0; i_cfg_data <= '0;
        i_mag_x <= '0; i_mag_y <= '0; i_mag_z <= '0;
        i_acc_x <= '0; i_acc_y <= '0; i_acc_z <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, reset limit
        send_sample(mk(0, 0, 0, 0, 0, 0));
        send_sample(mk(0, 0, 0, 500, 0, 0));          // acc_y and acc_z zero
        send_sample(mk(100, 0, 0, 0, 800, 0));        // acc_x and acc_z zero
        send_sample(mk(0, 0, 999, 0, 0, 16000));      // flat, Xh = Yh = 0
        send_sample(mk(1000, 0, 0, 0, 0, 16000));
        send_sample(mk(0, 1000, 0, 0, 0, 16000));
        send_sample(mk(-1000, 0, 0, 0, 0, 16000));
        send_sample(mk(0, -1000, 0, 0, 0, 16000));
        send_sample(mk(32767, -1, 0, 0, 0, 16000));   // wraps near full turn
        send_sample(mk(32767, -32768, -32768, 0, 0, 32767));
        send_sample(mk(-32768, 32767, 32767, -32768, -32768, -32768));
        send_sample(mk(32767, 32767, 32767, 32767, 32767, 32767));
        send_sample(mk(-32768, -32768, -32768, 32767, 32767, 1));
        send_sample(mk(5000, 3000, -2000, 12000, 0, 16000));   // pitch tilt, inside the reset limit
        send_sample(mk(5000, 3000, -2000, 0, -12000, 16000));  // roll tilt, inside the reset limit
        send_sample(mk(5000, 3000, -2000, 3000, 4000, -16000));
        send_sample(mk(-7000, 1200, 800, -5000, 6000, 12000));

        limits = '{14'd0, 14'd12868, 14'h3FFF, TILT_RESET, 14'd0};
        limits[4] = 14'($urandom_range(1, 12867));
        foreach (limits[p]) begin
            write_limit(limits[p]);
            for (int n = 0; n < PHASE_N; n++) begin
                if (p == 1 && n == PHASE_N / 2) drain();
                send_sample(rand_axes());
            end
        end

        start <= 1'b0;
        while (sb.pending.size() > 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (sb.fails == 0 && sb.pending.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
